### design/tce_pkg.sv
// Shared types and constants for the toy CPU execute unit.
package tce_pkg;

  typedef enum logic [2:0] {
    OP_MOV     = 3'd0,
    OP_ADD     = 3'd1,
    OP_CMP     = 3'd2,
    OP_JMP     = 3'd3,
    OP_JZ      = 3'd4,
    OP_JNZ     = 3'd5,
    OP_HALT    = 3'd6,
    OP_PRELOAD = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_IMM  = 2'd0,
    MODE_REG  = 2'd1,
    MODE_DIR  = 2'd2,
    MODE_IND  = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OPR = 2'd2;

  localparam int unsigned LEN_W = 9;

  // Last member sits in the lowest bits, matching the stream packing.
  typedef struct packed {
    logic [31:0]  src_value;
    logic         src_present;
    mode_t        src_mode;
    logic [30:0]  dest_value;
    logic         dest_present;
    mode_t        dest_mode;
    op_t          op;
  } instr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] written_value;
    logic        sign_flag;
    logic        zero_flag;
    logic [30:0] next_ip;
  } result_t;

endpackage

### design/toy_cpu_execute_unit.sv
// Top level of the toy CPU execute unit: queue front, execute back, APB registers.
//
//  channel | direction | contents
//  in_     | slave     | one pre-decoded instruction per item
//  out_    | master    | one result per item
//  cfg_    | APB       | code_length at 0x0, data_length at 0x4
//
// In the back stage an item goes through operand fetch with registered memory
// read, then execute and write-back. The two-entry queue accepts while it has a
// free entry, also while the back stage works or the output waits. Reset (rst_n,
// synchronous) clears registers, flags, pointer and lengths; data memory is not
// cleared. A stalled output holds the back stage.
module toy_cpu_execute_unit #(
  parameter int DATA_DEPTH = 256,
  parameter int CODE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0], dest_mode[4:3], dest_present[5], dest_value[36:6],
  // src_mode[38:37], src_present[39], src_value[71:40]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_ip[30:0], zero_flag[31], sign_flag[32], written_value[64:33], status[66:65]
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LW = tce_pkg::LEN_W;

  logic [LW-1:0] code_len_r, data_len_r;
  logic          cfg_wr;
  logic [LW-1:0] wv;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign wv         = cfg_pwdata[LW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_len_r <= '0;
      data_len_r <= '0;
    end else if (cfg_wr) begin
      // Saturate to the configured depth.
      if (cfg_paddr == 3'd0)
        code_len_r <= ({23'd0, wv} > 32'(CODE_DEPTH)) ? LW'(CODE_DEPTH) : wv;
      else if (cfg_paddr == 3'd4)
        data_len_r <= ({23'd0, wv} > 32'(DATA_DEPTH)) ? LW'(DATA_DEPTH) : wv;
    end
  end

  always_comb begin
    case (cfg_paddr)
      3'd0:    cfg_prdata = {23'd0, code_len_r};
      3'd4:    cfg_prdata = {23'd0, data_len_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  tce_pkg::instr_t  in_instr, q_instr;
  tce_pkg::result_t res;
  logic             q_valid, q_ready;

  assign in_instr = tce_pkg::instr_t'(in_tdata);

  tce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_instr (in_instr),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_instr  (q_instr)
  );

  tce_back #(.DATA_DEPTH(DATA_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_instr     (q_instr),
    .code_length (code_len_r),
    .data_length (data_len_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {5'd0, res.status, res.written_value, res.sign_flag,
                      res.zero_flag, res.next_ip};

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(data_len_r) <= 32'(DATA_DEPTH)) else $error("data length above depth");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.status == tce_pkg::ST_OK || res.status == tce_pkg::ST_BAD_OPR))
    else $error("bad status");
  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.status == tce_pkg::ST_BAD_OPR) |-> res.written_value == 32'd0)
    else $error("write on error");
`endif

endmodule

### design/tce_front.sv
// Input stage and two-entry instruction queue for the execute unit.
module tce_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tce_pkg::instr_t in_instr,
  output logic            q_valid,
  input  logic            q_ready,
  output tce_pkg::instr_t q_instr
);

  tce_pkg::instr_t ent_r [2];
  logic            rd_r, rd_nxt;
  logic            wr_r, wr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_instr  = ent_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= in_instr;
    end
  end

endmodule

### design/tce_back.sv
// Execution stage: operand fetch, memory read, execute and write-back.
module tce_back #(
  parameter int DATA_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  tce_pkg::instr_t         q_instr,
  input  logic [tce_pkg::LEN_W-1:0] code_length,
  input  logic [tce_pkg::LEN_W-1:0] data_length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tce_pkg::result_t        out_res
);

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  logic [31:0] mem [DATA_DEPTH];
  logic [31:0] gpr_r [4];
  logic [31:0] ip_r;
  logic        zf_r, sf_r;

  // Stage 1 holds the item while the memory read completes.
  logic            s1_r;
  tce_pkg::instr_t i1_r;
  logic            dok_r, sok_r, dmem_r, smem_r;
  logic [AW-1:0]   da_r;
  logic [31:0]     dv_r, sv_r;
  logic [31:0]     drd_r, srd_r;

  logic            ores_v_r;
  tce_pkg::result_t ores_r;

  // Operand resolution against registers and address range.
  function automatic logic addr_ok(input logic [31:0] a, input logic [8:0] len);
    logic r;
    r = ({23'd0, len} > a) && (a < 32'(DATA_DEPTH));
    return r;
  endfunction

  logic [31:0] d_addr, s_addr;
  logic        d_ok, s_ok, d_mem, s_mem;
  logic [31:0] d_imm, s_imm;

  always_comb begin
    d_ok = 1'b0; d_mem = 1'b0; d_imm = {1'b0, q_instr.dest_value};
    d_addr = {1'b0, q_instr.dest_value};
    case (q_instr.dest_mode)
      tce_pkg::MODE_IMM: d_ok = 1'b1;
      tce_pkg::MODE_REG: begin
        d_ok = q_instr.dest_value < 31'd4;
        d_imm = gpr_r[q_instr.dest_value[1:0]];
      end
      tce_pkg::MODE_DIR: begin
        d_mem = 1'b1;
        d_ok = addr_ok(d_addr, data_length);
      end
      tce_pkg::MODE_IND: begin
        d_mem = 1'b1;
        d_addr = gpr_r[q_instr.dest_value[1:0]];
        d_ok = (q_instr.dest_value < 31'd4) && addr_ok(d_addr, data_length);
      end
      default: d_ok = 1'b0;
    endcase
    d_ok = d_ok && q_instr.dest_present;

    s_ok = 1'b0; s_mem = 1'b0; s_imm = q_instr.src_value;
    s_addr = q_instr.src_value;
    case (q_instr.src_mode)
      tce_pkg::MODE_IMM: s_ok = 1'b1;
      tce_pkg::MODE_REG: begin
        s_ok = q_instr.src_value < 32'd4;
        s_imm = gpr_r[q_instr.src_value[1:0]];
      end
      tce_pkg::MODE_DIR: begin
        s_mem = 1'b1;
        s_ok = addr_ok(s_addr, data_length);
      end
      tce_pkg::MODE_IND: begin
        s_mem = 1'b1;
        s_addr = gpr_r[q_instr.src_value[1:0]];
        s_ok = (q_instr.src_value < 32'd4) && addr_ok(s_addr, data_length);
      end
      default: s_ok = 1'b0;
    endcase
    s_ok = s_ok && q_instr.src_present;
  end

  // One item in flight; stage 1 results are written back before next fetch.
  logic s2_go;
  assign s2_go   = s1_r && (!ores_v_r || out_ready);
  assign q_ready = !s1_r;

  logic        take;
  assign take = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      i1_r   <= q_instr;
      dok_r  <= d_ok;
      sok_r  <= s_ok;
      dmem_r <= d_mem;
      smem_r <= s_mem;
      da_r   <= AW'(d_addr);
      dv_r   <= d_imm;
      sv_r   <= s_imm;
      drd_r  <= mem[AW'(d_addr)];
      srd_r  <= mem[AW'(s_addr)];
    end
  end

  // Execute.
  logic [31:0] dval, sval, wv, diff, ip_nxt, wr_val;
  logic        zf_nxt, sf_nxt, taken, reg_wr, mem_wr;
  logic [AW-1:0] mem_a;
  logic [1:0]  st;
  logic [31:0] pre_a;

  always_comb begin
    dval   = dmem_r ? drd_r : dv_r;
    sval   = smem_r ? srd_r : sv_r;
    diff   = dval - sval;
    ip_nxt = ip_r + 32'd1;
    zf_nxt = zf_r;
    sf_nxt = sf_r;
    wv     = 32'd0;
    wr_val = (i1_r.op == tce_pkg::OP_MOV) ? sval : dval + sval;
    reg_wr = 1'b0;
    mem_wr = 1'b0;
    mem_a  = da_r;
    st     = tce_pkg::ST_OK;
    taken  = 1'b0;
    pre_a  = {1'b0, i1_r.dest_value};
    case (i1_r.op)
      tce_pkg::OP_MOV, tce_pkg::OP_ADD, tce_pkg::OP_CMP: begin
        if (!(dok_r && sok_r)) begin
          st = tce_pkg::ST_BAD_OPR;
        end else if (i1_r.op == tce_pkg::OP_CMP) begin
          zf_nxt = (diff == 32'd0);
          sf_nxt = diff[31];
        end else if (i1_r.dest_mode != tce_pkg::MODE_IMM) begin
          wv     = wr_val;
          reg_wr = (i1_r.dest_mode == tce_pkg::MODE_REG);
          mem_wr = dmem_r;
        end
      end
      tce_pkg::OP_JMP, tce_pkg::OP_JZ, tce_pkg::OP_JNZ: begin
        taken = (i1_r.op == tce_pkg::OP_JMP) || (i1_r.op == tce_pkg::OP_JZ && zf_r) ||
                (i1_r.op == tce_pkg::OP_JNZ && !zf_r);
        if (taken) begin
          if (dok_r) ip_nxt = dval;
          else st = tce_pkg::ST_BAD_OPR;
        end
      end
      tce_pkg::OP_HALT: ip_nxt = {23'd0, code_length};
      tce_pkg::OP_PRELOAD: begin
        ip_nxt = ip_r;
        mem_a  = AW'(pre_a);
        if (addr_ok(pre_a, data_length)) begin
          mem_wr = 1'b1;
          wv     = i1_r.src_value;
        end else begin
          st = tce_pkg::ST_BAD_OPR;
        end
      end
      default: st = tce_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_go && mem_wr) begin
      mem[mem_a] <= wv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r     <= 1'b0;
      ores_v_r <= 1'b0;
      ip_r     <= 32'd0;
      zf_r     <= 1'b0;
      sf_r     <= 1'b0;
      for (int i = 0; i < 4; i++) gpr_r[i] <= 32'd0;
    end else begin
      if (take) s1_r <= 1'b1;
      else if (s2_go) s1_r <= 1'b0;
      if (s2_go) begin
        ores_v_r <= 1'b1;
        ip_r     <= ip_nxt;
        zf_r     <= zf_nxt;
        sf_r     <= sf_nxt;
        if (reg_wr) gpr_r[i1_r.dest_value[1:0]] <= wv;
      end else if (out_ready) begin
        ores_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      ores_r.next_ip       <= ip_nxt[30:0];
      ores_r.zero_flag     <= zf_nxt;
      ores_r.sign_flag     <= sf_nxt;
      ores_r.written_value <= wv;
      ores_r.status        <= st;
    end
  end

  assign out_valid = ores_v_r;
  assign out_res   = ores_r;

endmodule

### tb/toy_cpu_execute_unit_tb.sv
// Self-checking testbench for the toy CPU execute unit: random and directed instructions.
`timescale 1ns / 1ps
module toy_cpu_execute_unit_tb;

  localparam int DEPTH = 256;
  localparam int LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam logic [2:0] ADDR_CODE_LEN = 3'd0;
  localparam logic [2:0] ADDR_DATA_LEN = 3'd4;

  toy_cpu_execute_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  logic [31:0] cpu_regs [4];
  logic [31:0] cpu_ip;
  logic        cpu_zf, cpu_sf;
  logic [31:0] cpu_mem [DEPTH];
  bit          mem_known [DEPTH];
  logic [8:0]  code_len, data_len;

  tce_pkg::result_t result_q [$];
  int  mismatches = 0;
  int  cycles = 0;
  int  send_idle = 0;
  int  recv_stall = 0;

  function automatic bit addr_in_range(logic [31:0] a);
    return a < data_len && a < DEPTH;
  endfunction

  // Resolve an operand: kind 0 imm, 1 reg, 2 mem.
  function automatic bit fetch_operand(tce_pkg::mode_t m, bit pres, logic [31:0] raw,
                                       output int kind, output logic [31:0] loc,
                                       output logic [31:0] val);
    logic [31:0] a;
    kind = 0; loc = '0; val = '0;
    if (!pres) return 0;
    case (m)
      tce_pkg::MODE_IMM: begin
        val = raw;
        return 1;
      end
      tce_pkg::MODE_REG: begin
        if (raw > 3) return 0;
        kind = 1; loc = raw; val = cpu_regs[raw[1:0]];
        return 1;
      end
      tce_pkg::MODE_DIR: a = raw;
      default: begin
        if (raw > 3) return 0;
        a = cpu_regs[raw[1:0]];
      end
    endcase
    if (!addr_in_range(a)) return 0;
    kind = 2; loc = a; val = cpu_mem[a[7:0]];
    return 1;
  endfunction

  function automatic tce_pkg::result_t execute_instr(tce_pkg::instr_t ins);
    tce_pkg::result_t r;
    int dk, sk;
    logic [31:0] dl, dv, sl, sv, v;
    bit taken;
    r = '0;
    if (ins.op == tce_pkg::OP_PRELOAD) begin
      if (addr_in_range({1'b0, ins.dest_value})) begin
        cpu_mem[ins.dest_value[7:0]] = ins.src_value;
        mem_known[ins.dest_value[7:0]] = 1;
        r.written_value = ins.src_value;
      end else r.status = tce_pkg::ST_BAD_OPR;
    end else begin
      cpu_ip = cpu_ip + 32'd1;
      case (ins.op)
        tce_pkg::OP_MOV, tce_pkg::OP_ADD, tce_pkg::OP_CMP: begin
          if (!fetch_operand(ins.dest_mode, ins.dest_present, {1'b0, ins.dest_value},
                             dk, dl, dv) ||
              !fetch_operand(ins.src_mode, ins.src_present, ins.src_value, sk, sl, sv))
            r.status = tce_pkg::ST_BAD_OPR;
          else if (ins.op == tce_pkg::OP_CMP) begin
            v = dv - sv;
            cpu_zf = (v == 0);
            cpu_sf = v[31];
          end else begin
            v = (ins.op == tce_pkg::OP_MOV) ? sv : dv + sv;
            if (dk == 1) cpu_regs[dl[1:0]] = v;
            if (dk == 2) begin
              cpu_mem[dl[7:0]] = v;
              mem_known[dl[7:0]] = 1;
            end
            if (dk != 0) r.written_value = v;
          end
        end
        tce_pkg::OP_JMP, tce_pkg::OP_JZ, tce_pkg::OP_JNZ: begin
          taken = ins.op == tce_pkg::OP_JMP || (ins.op == tce_pkg::OP_JZ && cpu_zf) ||
                  (ins.op == tce_pkg::OP_JNZ && !cpu_zf);
          if (taken) begin
            if (fetch_operand(ins.dest_mode, ins.dest_present, {1'b0, ins.dest_value},
                              dk, dl, dv))
              cpu_ip = dv;
            else r.status = tce_pkg::ST_BAD_OPR;
          end
        end
        default: cpu_ip = {23'd0, code_len};
      endcase
    end
    r.next_ip = cpu_ip[30:0];
    r.zero_flag = cpu_zf;
    r.sign_flag = cpu_sf;
    return r;
  endfunction

  // Would this operand read an unwritten word?
  function automatic bit reads_unknown(tce_pkg::mode_t m, bit pres, logic [31:0] raw);
    logic [31:0] a;
    if (!pres || m == tce_pkg::MODE_IMM || m == tce_pkg::MODE_REG) return 0;
    if (m == tce_pkg::MODE_DIR) a = raw;
    else begin
      if (raw > 3) return 0;
      a = cpu_regs[raw[1:0]];
    end
    return addr_in_range(a) && !mem_known[a[7:0]];
  endfunction

  function automatic bit instr_is_legal(tce_pkg::instr_t ins);
    bit taken;
    case (ins.op)
      tce_pkg::OP_MOV, tce_pkg::OP_ADD, tce_pkg::OP_CMP: begin
        if (reads_unknown(ins.dest_mode, ins.dest_present, {1'b0, ins.dest_value}))
          return 0;
        return !reads_unknown(ins.src_mode, ins.src_present, ins.src_value);
      end
      tce_pkg::OP_JMP, tce_pkg::OP_JZ, tce_pkg::OP_JNZ: begin
        taken = ins.op == tce_pkg::OP_JMP || (ins.op == tce_pkg::OP_JZ && cpu_zf) ||
                (ins.op == tce_pkg::OP_JNZ && !cpu_zf);
        return !taken ||
               !reads_unknown(ins.dest_mode, ins.dest_present, {1'b0, ins.dest_value});
      end
      default: return 1;
    endcase
  endfunction

  task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_CODE_LEN) code_len = val[8:0] > DEPTH ? 9'(DEPTH) : val[8:0];
    else data_len = val[8:0] > DEPTH ? 9'(DEPTH) : val[8:0];
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Send one instruction; illegal reads of unwritten memory are skipped.
  task automatic send_instr(tce_pkg::instr_t ins);
    if (!instr_is_legal(ins)) return;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= ins;
    in_tvalid <= 1'b1;
    result_q.push_back(execute_instr(ins));
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic tce_pkg::instr_t mk(tce_pkg::op_t op, tce_pkg::mode_t dm, bit dp,
                                         logic [30:0] dv, tce_pkg::mode_t sm, bit sp,
                                         logic [31:0] sv);
    tce_pkg::instr_t i;
    i.op = op; i.dest_mode = dm; i.dest_present = dp; i.dest_value = dv;
    i.src_mode = sm; i.src_present = sp; i.src_value = sv;
    return i;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return $urandom_range(300);
      2: return 32'h7fff_ff00 + $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic tce_pkg::instr_t rand_instr();
    tce_pkg::instr_t i;
    logic [31:0] d;
    i.op = tce_pkg::op_t'($urandom_range(7));
    i.dest_mode = tce_pkg::mode_t'($urandom_range(3));
    i.src_mode = tce_pkg::mode_t'($urandom_range(3));
    i.dest_present = $urandom_range(15) != 0;
    i.src_present = $urandom_range(15) != 0;
    d = rand_value();
    i.dest_value = d[30:0];
    i.src_value = (i.op == tce_pkg::OP_PRELOAD) ? $urandom : rand_value();
    if (i.op == tce_pkg::OP_PRELOAD && $urandom_range(3) != 0)
      i.dest_value = 31'($urandom_range(255));
    return i;
  endfunction

  task automatic test_directed();
    cfg_write(ADDR_CODE_LEN, 32'd256);
    cfg_write(ADDR_DATA_LEN, 32'd256);
    send_instr(mk(tce_pkg::OP_PRELOAD, tce_pkg::MODE_IMM, 0, 31'd0,
                  tce_pkg::MODE_IMM, 0, 32'h8000_0000));
    send_instr(mk(tce_pkg::OP_PRELOAD, tce_pkg::MODE_IMM, 0, 31'd255,
                  tce_pkg::MODE_IMM, 0, 32'hffff_ffff));
    send_instr(mk(tce_pkg::OP_PRELOAD, tce_pkg::MODE_IMM, 0, 31'd256,
                  tce_pkg::MODE_IMM, 0, 32'd5));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_REG, 1, 31'd0,
                  tce_pkg::MODE_IMM, 1, 32'h7fff_ffff));
    send_instr(mk(tce_pkg::OP_ADD, tce_pkg::MODE_REG, 1, 31'd0,
                  tce_pkg::MODE_IMM, 1, 32'd1));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_REG, 1, 31'd1,
                  tce_pkg::MODE_DIR, 1, 32'd255));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_DIR, 1, 31'd3,
                  tce_pkg::MODE_REG, 1, 32'd1));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_REG, 1, 31'd2,
                  tce_pkg::MODE_IMM, 1, 32'd3));
    send_instr(mk(tce_pkg::OP_ADD, tce_pkg::MODE_IND, 1, 31'd2,
                  tce_pkg::MODE_IND, 1, 32'd2));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_IMM, 1, 31'd9,
                  tce_pkg::MODE_IMM, 1, 32'd1));
    send_instr(mk(tce_pkg::OP_CMP, tce_pkg::MODE_REG, 1, 31'd2,
                  tce_pkg::MODE_IMM, 1, 32'd3));
    send_instr(mk(tce_pkg::OP_JZ, tce_pkg::MODE_IMM, 1, 31'h7fff_ffff,
                  tce_pkg::MODE_IMM, 0, 32'd0));
    send_instr(mk(tce_pkg::OP_JNZ, tce_pkg::MODE_IMM, 0, 31'd0,
                  tce_pkg::MODE_IMM, 0, 32'd0));
    send_instr(mk(tce_pkg::OP_CMP, tce_pkg::MODE_REG, 1, 31'd2,
                  tce_pkg::MODE_IMM, 1, 32'd4));
    send_instr(mk(tce_pkg::OP_JNZ, tce_pkg::MODE_REG, 1, 31'd0,
                  tce_pkg::MODE_IMM, 0, 32'd0));
    send_instr(mk(tce_pkg::OP_CMP, tce_pkg::MODE_REG, 1, 31'd2,
                  tce_pkg::MODE_IMM, 1, 32'd1));
    send_instr(mk(tce_pkg::OP_JMP, tce_pkg::MODE_REG, 1, 31'd7,
                  tce_pkg::MODE_IMM, 0, 32'd0));
    send_instr(mk(tce_pkg::OP_JMP, tce_pkg::MODE_DIR, 1, 31'd0,
                  tce_pkg::MODE_IMM, 0, 32'd0));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_REG, 0, 31'd0,
                  tce_pkg::MODE_IMM, 1, 32'd1));
    send_instr(mk(tce_pkg::OP_MOV, tce_pkg::MODE_REG, 1, 31'd0,
                  tce_pkg::MODE_DIR, 1, 32'h8000_0000));
    send_instr(mk(tce_pkg::OP_HALT, tce_pkg::MODE_IMM, 0, 31'd0,
                  tce_pkg::MODE_IMM, 0, 32'd0));
    drain();
  endtask

  task automatic test_random_phase(int n, int sidle, int rstall, int clen, int dlen);
    tce_pkg::instr_t ins;
    cfg_write(ADDR_CODE_LEN, 32'(clen));
    cfg_write(ADDR_DATA_LEN, 32'(dlen));
    send_idle = sidle;
    recv_stall = rstall;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();  // hold off until all results are in
      do ins = rand_instr(); while (!instr_is_legal(ins));
      send_instr(ins);
    end
    drain();
  endtask

  // Receiver stall and result check
  always @(posedge clk) begin
    out_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    if (rst_n && out_tvalid && out_tready) begin
      tce_pkg::result_t got, want;
      got = out_tdata[66:0];
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = result_q.pop_front();
        if (got.next_ip !== want.next_ip || got.zero_flag !== want.zero_flag ||
            got.sign_flag !== want.sign_flag || got.written_value !== want.written_value ||
            got.status !== want.status || out_tdata[71:67] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h, got %h", want, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("toy_cpu_execute_unit test failed");
      $finish;
    end
  end

  initial begin
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    foreach (mem_known[i]) mem_known[i] = 0;
    cpu_ip = '0; cpu_zf = 0; cpu_sf = 0; code_len = '0; data_len = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(300, 0, 0, 256, 256);
    test_random_phase(200, 85, 0, 0, 16);
    test_random_phase(200, 0, 85, 511, 511);
    test_random_phase(200, 28, 28, 100, 200);
    test_random_phase(100, 0, 0, 3, 0);
    if (result_q.size() == 0 && mismatches == 0)
      $display("toy_cpu_execute_unit test passed");
    else
      $display("toy_cpu_execute_unit test failed");
    $finish;
  end

endmodule
